// File: design/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;
    localparam int W = 16;
    localparam int PW = 2 * W;
    localparam int NW = 33;
    localparam int DW = 32;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_CMP = 3'd4;
    localparam logic [2:0] KIND_SIMP = 3'd5;

    typedef struct packed {
        logic load;
        logic prod1;
        logic prod2;
        logic finish;
        logic gcd_step;
        logic div_init;
        logic div_step;
    } rau_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic simp_zero;
    } rau_status_t;
endpackage

// File: design/rau_datapath.sv
`timescale 1ns / 1ps
module rau_datapath
    import rau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_cmd_t          cmd,
    output rau_status_t       status,
    input  logic [2:0]        kind,
    input  logic [15:0]       a_num,
    input  logic [15:0]       a_den,
    input  logic [15:0]       b_num,
    input  logic [15:0]       b_den,
    output logic [NW-1:0]     result_num,
    output logic [DW-1:0]     result_den,
    output logic              less,
    output logic              equal,
    output logic              greater,
    output logic              zero_denominator
);
    logic [2:0] kind_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic [W:0] gx_reg, gy_reg;
    logic [W:0] dq_reg, dr_reg, dd_reg;
    logic [W:0] qn_reg;
    logic [$clog2(W+2)-1:0] dcnt_reg;
    logic dsel_reg;

    logic [NW-1:0] result_num_reg, result_num_next;
    logic [DW-1:0] result_den_reg, result_den_next;
    logic less_reg, less_next;
    logic equal_reg, equal_next;
    logic greater_reg, greater_next;
    logic zero_den_reg, zero_den_next;

    logic signed [W:0] ne_a, de_a, ne_b, de_b;
    logic signed [W:0] m1a, m1b;
    logic signed [2*W+1:0] mprod;
    logic [W:0] mag_an, mag_ad;
    logic [W+1:0] rtrial;
    logic [W:0] rshift;

    assign mag_an = an_reg[W-1] ? -{an_reg[W-1], an_reg} : {1'b0, an_reg};
    assign mag_ad = ad_reg[W-1] ? -{ad_reg[W-1], ad_reg} : {1'b0, ad_reg};

    always_comb
    begin
        ne_a = {an_reg[W-1], an_reg};
        de_a = {ad_reg[W-1], ad_reg};
        ne_b = {bn_reg[W-1], bn_reg};
        de_b = {bd_reg[W-1], bd_reg};
        if (kind_reg == KIND_CMP)
        begin
            if (ad_reg[W-1])
            begin
                ne_a = -ne_a;
                de_a = -de_a;
            end
            if (bd_reg[W-1])
            begin
                ne_b = -ne_b;
                de_b = -de_b;
            end
        end
        // first product (prod1): numerator side, second (prod2): denominator / other cross
        m1a = ne_a;
        m1b = de_b;
        if (cmd.prod2)
        begin
            case (kind_reg)
                KIND_MUL: begin m1a = de_a; m1b = de_b; end
                KIND_DIV: begin m1a = de_a; m1b = ne_b; end
                KIND_CMP: begin m1a = ne_b; m1b = de_a; end
                default:  begin m1a = de_a; m1b = ne_b; end
            endcase
        end
        else if (kind_reg == KIND_MUL)
            m1b = ne_b;
        mprod = m1a * m1b;
    end

    logic signed [PW+1:0] ddd;
    logic signed [PW:0] e1, e2;
    assign e1 = {p1_reg[PW-1], p1_reg};
    assign e2 = {p2_reg[PW-1], p2_reg};

    assign rtrial = {dr_reg, dq_reg[W]} - {1'b0, dd_reg};
    assign rshift = dq_reg << 1;

    assign status.gcd_done = (gy_reg == '0);
    assign status.div_done = (dcnt_reg == '0);
    assign status.simp_zero = (ad_reg == '0);

    assign result_num = result_num_reg;
    assign result_den = result_den_reg;
    assign less = less_reg;
    assign equal = equal_reg;
    assign greater = greater_reg;
    assign zero_denominator = zero_den_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            an_reg <= a_num[W-1:0];
            ad_reg <= a_den[W-1:0];
            bn_reg <= b_num[W-1:0];
            bd_reg <= b_den[W-1:0];
            gx_reg <= '0;
            gy_reg <= '0;
        end
        if (cmd.prod1)
        begin
            p1_reg <= mprod[PW-1:0];
            gx_reg <= mag_an;
            gy_reg <= mag_ad;
        end
        if (cmd.prod2)
            p2_reg <= mprod[PW-1:0];
        if (cmd.gcd_step)
        begin
            // subtractive euclid: subtract or swap, one step per cycle
            if (gx_reg >= gy_reg)
                gx_reg <= gx_reg - gy_reg;
            else
            begin
                gx_reg <= gy_reg;
                gy_reg <= gx_reg;
            end
        end
        if (cmd.div_init)
        begin
            dd_reg <= gx_reg;
            dq_reg <= dsel_reg ? mag_ad : mag_an;
            dr_reg <= '0;
            dcnt_reg <= ($clog2(W+2))'(W + 1);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (!rtrial[W+1])
            begin
                dr_reg <= rtrial[W:0];
                dq_reg <= rshift | (W+1)'(1);
            end
            else
            begin
                dr_reg <= {dr_reg[W-1:0], dq_reg[W]};
                dq_reg <= rshift;
            end
            // keep the numerator quotient from the first division
            if (!dsel_reg && dcnt_reg == ($clog2(W+2))'(1))
                qn_reg <= (!rtrial[W+1]) ? (rshift | (W+1)'(1)) : rshift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dsel_reg <= 1'b0;
        else if (cmd.load)
            dsel_reg <= 1'b0;
        else if (cmd.div_step && dcnt_reg == ($clog2(W+2))'(1))
            dsel_reg <= 1'b1;
    end

    always_comb
    begin
        ddd = (kind_reg == KIND_ADD) ? (e1 + e2) : (e1 - e2);
        result_num_next = '0;
        result_den_next = '0;
        less_next = 1'b0;
        equal_next = 1'b0;
        greater_next = 1'b0;
        zero_den_next = 1'b0;
        case (kind_reg)
            KIND_ADD, KIND_SUB:
            begin
                result_num_next = NW'(ddd);
                result_den_next = DW'(signed'(ad_reg) * signed'(bd_reg));
                zero_den_next = (ad_reg == '0) || (bd_reg == '0);
            end
            KIND_MUL, KIND_DIV:
            begin
                result_num_next = NW'(e1);
                result_den_next = DW'(e2);
                zero_den_next = (ad_reg == '0) ||
                    ((kind_reg == KIND_MUL) ? (bd_reg == '0) : (bn_reg == '0));
            end
            KIND_CMP:
            begin
                less_next = p1_reg < p2_reg;
                equal_next = p1_reg == p2_reg;
                greater_next = p1_reg > p2_reg;
                zero_den_next = (ad_reg == '0) || (bd_reg == '0);
            end
            KIND_SIMP:
            begin
                if (ad_reg == '0)
                begin
                    zero_den_next = 1'b1;
                    result_num_next = NW'(an_reg);
                end
                else
                begin
                    result_num_next = an_reg[W-1] ? -NW'(qn_reg) : NW'(qn_reg);
                    result_den_next = ad_reg[W-1] ? -DW'(dq_reg) : DW'(dq_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_num_reg <= result_num_next;
            result_den_reg <= result_den_next;
            less_reg <= less_next;
            equal_reg <= equal_next;
            greater_reg <= greater_next;
            zero_den_reg <= zero_den_next;
        end
    end
endmodule

// File: design/rau_ctrl.sv
`timescale 1ns / 1ps
module rau_ctrl
    import rau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  kind,
    input  rau_status_t status,
    output rau_cmd_t    cmd,
    output logic        busy,
    output logic        done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_P1 = 3'd1;
    localparam logic [2:0] S_P2 = 3'd2;
    localparam logic [2:0] S_GCD = 3'd3;
    localparam logic [2:0] S_D1I = 3'd4;
    localparam logic [2:0] S_DIV = 3'd5;
    localparam logic [2:0] S_FIN = 3'd6;

    logic [2:0] state_reg, state_next;
    logic simp_reg, simp_next, second_reg, second_next, done_reg;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        simp_next = simp_reg;
        second_next = second_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.load = 1'b1;
                    simp_next = (kind == KIND_SIMP);
                    second_next = 1'b0;
                    state_next = S_P1;
                end
            S_P1:
            begin
                cmd.prod1 = 1'b1;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd.prod2 = 1'b1;
                state_next = (simp_reg && !status.simp_zero) ? S_GCD : S_FIN;
            end
            S_GCD:
                if (status.gcd_done)
                    state_next = S_D1I;
                else
                    cmd.gcd_step = 1'b1;
            S_D1I:
            begin
                cmd.div_init = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
                if (status.div_done)
                begin
                    second_next = 1'b1;
                    state_next = second_reg ? S_FIN : S_D1I;
                end
                else
                    cmd.div_step = 1'b1;
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            simp_reg <= 1'b0;
            second_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            simp_reg <= simp_next;
            second_reg <= second_next;
            done_reg <= cmd.finish;
        end
    end

`ifndef SYNTHESIS
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == S_IDLE && done_reg) else $error("finish");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done pulse");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load");
`endif
endmodule

// File: design/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// one item at a time: start is taken while busy is low, and busy stays high
// until the result is out; add, subtract, multiply, divide, compare, the unused
// kinds and simplify with a zero denominator keep busy high after the transfer
// for two products through the shared multiplier, then the result register,
// and raise done as busy falls; simplify with a nonzero denominator runs a
// subtractive gcd (one subtract or swap per cycle, n steps: few for small
// values, about 2^15 in the worst case such as 32767 over -32768) and two
// 17-step restoring divisions before the result register; done pulses for one
// cycle with the result and cannot be held off by the receiver
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    input  logic [2:0]    kind,
    input  logic [15:0]   a_num,
    input  logic [15:0]   a_den,
    input  logic [15:0]   b_num,
    input  logic [15:0]   b_den,
    output logic [32:0]   result_num,
    output logic [31:0]   result_den,
    output logic          less,
    output logic          equal,
    output logic          greater,
    output logic          zero_denominator
);
    rau_cmd_t cmd;
    rau_status_t status;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(kind),
        .status(status), .cmd(cmd), .busy(busy), .done(done)
    );

    rau_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .result_num(result_num), .result_den(result_den), .less(less),
        .equal(equal), .greater(greater), .zero_denominator(zero_denominator)
    );
endmodule
